// ===== rtl/b64d_pkg.sv =====
// Shared constants, types and the character map of the base64 stream decoder.
package b64d_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TOTAL_WIDTH = COUNT_WIDTH + 1;
    localparam int LIMIT_WIDTH = 16;
    localparam int RESULT_COUNT_WIDTH = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    localparam logic [0:0] REG_URL_MODE = 1'd0;
    localparam logic [0:0] REG_OUTPUT_LIMIT = 1'd1;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;

    localparam logic [6:0] PAD_CODE = 7'd64;
    localparam logic [6:0] BAD_CODE = 7'd65;

    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD = 8'h3D;
    localparam logic [7:0] CH_END = 8'h00;

    // One unit of work for the result side: up to three bytes, then an optional done.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nbytes;
        logic done;
        logic [RESULT_COUNT_WIDTH-1:0] count;
    } job_t;

    function automatic logic [6:0] map_char(input logic [7:0] c, input logic url);
        logic [6:0] code;
        code = BAD_CODE;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            code = 7'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            code = 7'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            code = 7'(c - 8'h30 + 8'd52);
        end
        else if (c == CH_PAD)
        begin
            code = PAD_CODE;
        end
        else if (url && c == CH_DASH)
        begin
            code = 7'd62;
        end
        else if (url && c == CH_UNDER)
        begin
            code = 7'd63;
        end
        else if (!url && c == CH_PLUS)
        begin
            code = 7'd62;
        end
        else if (!url && c == CH_SLASH)
        begin
            code = 7'd63;
        end
        return code;
    endfunction

endpackage

// ===== rtl/b64d_front.sv =====
// Front end: takes characters, keeps the group and limit state, and issues jobs.
module b64d_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                q_full,
    input  logic [7:0]                          char_code,
    input  logic                                wr_en,
    input  logic [0:0]                          wr_index,
    input  logic [b64d_pkg::LIMIT_WIDTH-1:0]    wr_data,
    output logic                                job_push,
    output b64d_pkg::job_t                      job
);

    logic                                   url_mode_reg;
    logic [b64d_pkg::LIMIT_WIDTH-1:0]       limit_reg;
    logic [5:0]                             store_reg [3];
    logic [1:0]                             group_reg, group_next;
    logic [b64d_pkg::COUNT_WIDTH-1:0]       room_reg, room_next;
    logic [b64d_pkg::TOTAL_WIDTH-1:0]       total_reg, total_next;
    logic                                   drain_reg, drain_next;

    logic                                   accept;
    logic [6:0]                             code;
    logic [5:0]                             s3;
    logic [1:0]                             nb_group;
    logic [1:0]                             nb;
    logic [b64d_pkg::TOTAL_WIDTH-1:0]       total_sum;
    logic [b64d_pkg::COUNT_WIDTH-1:0]       nb_ext;
    logic [b64d_pkg::COUNT_WIDTH-1:0]       room_charged;
    logic [b64d_pkg::COUNT_WIDTH-1:0]       room_load;
    logic                                   store_we;

    assign accept = push && !q_full;
    assign code = b64d_pkg::map_char(char_code, url_mode_reg);
    assign room_load = b64d_pkg::COUNT_WIDTH'(limit_reg);

    always_comb
    begin
        group_next = group_reg;
        room_next = room_reg;
        total_next = total_reg;
        drain_next = drain_reg;
        store_we = 1'b0;
        nb = 2'd0;
        job_push = 1'b0;
        s3 = 6'd0;

        // A full group uses the current character as its fourth sextet.
        if (code != b64d_pkg::PAD_CODE && code != b64d_pkg::BAD_CODE && group_reg == 2'd3)
        begin
            s3 = code[5:0];
            nb_group = 2'd3;
        end
        else
        begin
            nb_group = (group_reg > 2'd1) ? group_reg - 2'd1 : 2'd0;
        end

        job.b0 = {store_reg[0], store_reg[1][5:4]};
        job.b1 = {store_reg[1][3:0], store_reg[2][5:2]};
        job.b2 = {store_reg[2][1:0], s3};
        job.done = 1'b0;

        total_sum = b64d_pkg::TOTAL_WIDTH'(total_reg + b64d_pkg::TOTAL_WIDTH'(nb_group));
        nb_ext = b64d_pkg::COUNT_WIDTH'(nb_group);
        room_charged = (nb_ext >= room_reg) ? '0 : room_reg - nb_ext;
        job.count = b64d_pkg::RESULT_COUNT_WIDTH'(total_reg);

        if (accept)
        begin
            priority if (drain_reg)
            begin
                if (char_code == b64d_pkg::CH_END)
                begin
                    drain_next = 1'b0;
                    group_next = 2'd0;
                    total_next = '0;
                    room_next = room_load;
                end
            end
            else if (char_code == b64d_pkg::CH_END)
            begin
                // Standard mode drops a partial group; url mode flushes it.
                nb = url_mode_reg ? nb_group : 2'd0;
                job.done = 1'b1;
                job.count = url_mode_reg ? b64d_pkg::RESULT_COUNT_WIDTH'(total_sum)
                                         : b64d_pkg::RESULT_COUNT_WIDTH'(total_reg);
                group_next = 2'd0;
                total_next = '0;
                room_next = room_load;
                drain_next = 1'b0;
            end
            else if (room_reg == '0)
            begin
                job.done = 1'b1;
                drain_next = 1'b1;
            end
            else if (code == b64d_pkg::BAD_CODE)
            begin
                if (url_mode_reg)
                begin
                    nb = nb_group;
                    total_next = total_sum;
                    group_next = 2'd0;
                    job.done = 1'b1;
                    job.count = b64d_pkg::RESULT_COUNT_WIDTH'(total_sum);
                    drain_next = 1'b1;
                end
            end
            else if (code == b64d_pkg::PAD_CODE || group_reg == 2'd3)
            begin
                nb = nb_group;
                total_next = total_sum;
                room_next = room_charged;
                group_next = 2'd0;
                job.done = (room_charged == '0);
                job.count = b64d_pkg::RESULT_COUNT_WIDTH'(total_sum);
                drain_next = (room_charged == '0);
            end
            else
            begin
                store_we = 1'b1;
                group_next = group_reg + 2'd1;
            end
            job_push = (nb != 2'd0) || job.done;
        end
        job.nbytes = nb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            url_mode_reg <= 1'b0;
            limit_reg <= b64d_pkg::LIMIT_RESET;
            group_reg <= 2'd0;
            room_reg <= b64d_pkg::COUNT_WIDTH'(b64d_pkg::LIMIT_RESET);
            total_reg <= '0;
            drain_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            if (wr_index == b64d_pkg::REG_URL_MODE)
            begin
                url_mode_reg <= wr_data[0];
            end
            else
            begin
                limit_reg <= wr_data;
                room_reg <= b64d_pkg::COUNT_WIDTH'(wr_data);
            end
        end
        else
        begin
            group_reg <= group_next;
            room_reg <= room_next;
            total_reg <= total_next;
            drain_reg <= drain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[group_reg] <= code[5:0];
        end
    end

endmodule

// ===== rtl/b64d_queue.sv =====
// Short job queue that decouples the character side from the result side.
module b64d_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_push,
    input  b64d_pkg::job_t  q_wdata,
    output logic            q_full,
    input  logic            q_pop,
    output b64d_pkg::job_t  q_rdata,
    output logic            q_empty
);

    b64d_pkg::job_t                        entry_reg [b64d_pkg::QUEUE_DEPTH];
    logic [b64d_pkg::QPTR_WIDTH-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [b64d_pkg::QCOUNT_WIDTH-1:0]     count_reg, count_next;

    assign q_full = (count_reg == b64d_pkg::QCOUNT_WIDTH'(b64d_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({q_push, q_pop})
            2'b10: count_next = count_reg + 1'b1;
            2'b01: count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (q_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            entry_reg[wr_ptr_reg] <= q_wdata;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("job queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !q_pop)
        else $error("job queue read while empty");

endmodule

// ===== rtl/b64d_back.sv =====
// Back end: unrolls each job into byte results and a closing done result.
module b64d_back (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        q_empty,
    input  b64d_pkg::job_t                              q_rdata,
    output logic                                        q_pop,
    input  logic                                        pop,
    output logic                                        empty,
    output logic [7:0]                                  out_byte,
    output logic                                        byte_valid,
    output logic                                        done_res,
    output logic [b64d_pkg::RESULT_COUNT_WIDTH-1:0]     decoded_count,
    output logic                                        last_of_run
);

    b64d_pkg::job_t     cur_reg, cur_next;
    logic               valid_reg, valid_next;
    logic [1:0]         idx_reg, idx_next;
    logic               is_byte;
    logic               last;
    logic               take;
    logic [7:0]         sel_byte;

    assign is_byte = (idx_reg < cur_reg.nbytes);
    assign last = cur_reg.done ? (idx_reg == cur_reg.nbytes)
                               : (idx_reg == cur_reg.nbytes - 2'd1);
    assign take = pop && valid_reg;
    assign q_pop = !q_empty && (!valid_reg || (take && last));

    always_comb
    begin
        unique case (idx_reg)
            2'd0: sel_byte = cur_reg.b0;
            2'd1: sel_byte = cur_reg.b1;
            default: sel_byte = cur_reg.b2;
        endcase
    end

    assign empty = !valid_reg;
    assign out_byte = is_byte ? sel_byte : 8'd0;
    assign byte_valid = is_byte;
    assign done_res = !is_byte;
    assign decoded_count = is_byte ? '0 : cur_reg.count;
    assign last_of_run = last;

    always_comb
    begin
        cur_next = cur_reg;
        valid_next = valid_reg;
        idx_next = idx_reg;
        priority if (q_pop)
        begin
            cur_next = q_rdata;
            valid_next = 1'b1;
            idx_next = 2'd0;
        end
        else if (take && last)
        begin
            valid_next = 1'b0;
            idx_next = 2'd0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    a_job_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cur_reg.done || cur_reg.nbytes != 2'd0))
        else $error("job with no results reached the result side");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg <= cur_reg.nbytes))
        else $error("result index ran past its job");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last) |=> valid_reg)
        else $error("job dropped before its last result");

endmodule

// ===== rtl/base64_url_stream_decoder.sv =====
// Top level of the streaming base64 / base64url decoder.
// One character request is accepted per clock while the four-entry job queue has room;
// a character is classified and its group state updated in the cycle it is accepted, unless
// a register write comes in that cycle; each group, pad, invalid character or terminator that
// has something to report becomes one job. The result side serves one request per clock
// while pop is held and results are waiting; a job gives up to three bytes and a done result,
// and four characters of a full group give three byte results. A result passes through a
// queue entry and then the result-side job register. There is no clearing pass after reset.
module base64_url_stream_decoder (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        push,
    output logic                                        full,
    input  logic [7:0]                                  char_code,
    input  logic                                        wr_en,
    input  logic [0:0]                                  wr_index,
    input  logic [b64d_pkg::LIMIT_WIDTH-1:0]            wr_data,
    output logic                                        empty,
    input  logic                                        pop,
    output logic [7:0]                                  out_byte,
    output logic                                        byte_valid,
    output logic                                        done_res,
    output logic [b64d_pkg::RESULT_COUNT_WIDTH-1:0]     decoded_count,
    output logic                                        last_of_run
);

    logic               job_push;
    b64d_pkg::job_t     job_in;
    b64d_pkg::job_t     job_out;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;

    assign full = q_full;

    b64d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .q_full    (q_full),
        .char_code (char_code),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .job_push  (job_push),
        .job       (job_in)
    );

    b64d_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (job_push),
        .q_wdata (job_in),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_rdata (job_out),
        .q_empty (q_empty)
    );

    b64d_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_rdata       (job_out),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .done_res      (done_res),
        .decoded_count (decoded_count),
        .last_of_run   (last_of_run)
    );

endmodule
